@@ src/tofb_pkg.sv @@
// ----------------------------------------------------------------------------
// tofb_pkg : shared types, constants and helpers
// Field layouts, register indexes and stage sideband for the time-of-flight
// and velocity pipeline.
// ----------------------------------------------------------------------------
package tofb_pkg;

   // converter count width
   localparam int RAW_BITS = 12;
   localparam int PROD_W   = RAW_BITS + 32;

   // 1500 ps in 1/16 ps
   localparam logic signed [33:0] TIME_THRESHOLD = 34'sd24000;

   // floor(n/3) = (n * RECIP3) >> RECIP3_SHIFT for n below 2^20
   localparam logic [19:0] RECIP3       = 20'd699051;
   localparam int          RECIP3_SHIFT = 21;

   // square root and divider geometry
   localparam int ROOT_W      = 32;
   localparam int RADICAND_W  = 2 * ROOT_W;
   localparam int ROOT_STAGES = ROOT_W;
   localparam int QUO_W       = 32;
   localparam int DVS_W       = 32;
   localparam int NUM_W       = 48;
   localparam int DIV_STAGES  = QUO_W;

   // request beat layout
   localparam int IN_LEFT_LO  = 0;
   localparam int IN_RIGHT_LO = RAW_BITS;
   localparam int IN_START_LO = 2 * RAW_BITS;
   localparam int IN_START_OK = IN_START_LO + 16;
   localparam int IN_STOP_LO  = IN_START_OK + 1;
   localparam int IN_STOP_OK  = IN_STOP_LO + 16;
   localparam int REQ_BITS    = IN_STOP_OK + 1;
   localparam int REQ_W       = ((REQ_BITS + 7) / 8) * 8;

   // response beat layout
   localparam int RSP_BITS = 32 + 32 + 1 + 32 + 1 + 16 + 32 + 32;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEFT_SLOPE   = 3'd0,
      CSR_LEFT_OFFSET  = 3'd1,
      CSR_RIGHT_SLOPE  = 3'd2,
      CSR_RIGHT_OFFSET = 3'd3,
      CSR_BETA_BASE    = 3'd4,
      CSR_BETA_SCALE   = 3'd5,
      CSR_POS_CORR     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [31:0]        left_slope;
      logic signed [31:0] left_offset;
      logic [31:0]        right_slope;
      logic signed [31:0] right_offset;
      logic signed [31:0] beta_base_time;
      logic signed [31:0] beta_scale_time;
      logic               position_correction_on;
   } cfg_type;

   // sideband leaving the front end
   typedef struct packed {
      logic signed [31:0] left_cal;
      logic signed [31:0] right_cal;
      logic               flight_ok;
      logic signed [31:0] flight_time;
      logic               beta_ok;
      logic [31:0]        mag_a;
      logic [31:0]        mag_b;
   } side_type;

   // sideband through the dividers
   typedef struct packed {
      logic signed [31:0] left_cal;
      logic signed [31:0] right_cal;
      logic               flight_ok;
      logic signed [31:0] flight_time;
      logic               beta_ok;
      logic               gamma_sat;
      logic               bg_sat;
   } fin_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ src/tofb_front.sv @@
// ----------------------------------------------------------------------------
// tofb_front : calibration, flight time and beta operands
// Eight register stages: calibrate, average, position correction, divisor,
// magnitudes, squares and the square-root radicand.
// ----------------------------------------------------------------------------
module tofb_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [tofb_pkg::RAW_BITS-1:0] left_raw,
   input  logic [tofb_pkg::RAW_BITS-1:0] right_raw,
   input  logic signed [15:0]            start_position,
   input  logic                          start_position_ok,
   input  logic signed [15:0]            stop_position,
   input  logic                          stop_position_ok,
   input  tofb_pkg::cfg_type             cfg,
   output logic                          out_valid,
   output tofb_pkg::side_type            out_side,
   output logic [tofb_pkg::RADICAND_W-1:0] radicand
);

   localparam int PW = tofb_pkg::PROD_W;

   logic [7:0] v_ff;

   // stage 1
   logic [PW-1:0]      s1_prodl_ff, s1_prodr_ff;
   logic signed [16:0] s1_psum_ff;
   logic               s1_apply_ff;
   // stage 2
   logic signed [31:0] s2_lc_ff, s2_rc_ff, s2_lc_in, s2_rc_in;
   logic [19:0]        s2_n_ff;
   logic               s2_neg_ff, s2_apply_ff;
   logic [16:0]        s2_mag_in;
   // stage 3
   logic signed [31:0] s3_lc_ff, s3_rc_ff, s3_flight_ff;
   logic               s3_fok_ff, s3_neg_ff, s3_apply_ff;
   logic [39:0]        s3_q_ff;
   logic signed [32:0] s3_sum_in;
   // stage 4
   logic signed [31:0] s4_lc_ff, s4_rc_ff, s4_flight_ff, s4_flight_in;
   logic               s4_fok_ff;
   logic signed [33:0] s4_corr_in;
   // stage 5
   logic signed [31:0] s5_lc_ff, s5_rc_ff, s5_flight_ff;
   logic               s5_fok_ff;
   logic signed [32:0] s5_den_ff;
   // stage 6 onward carries the sideband struct
   tofb_pkg::side_type s6_side_ff, s7_side_ff, s8_side_ff;
   tofb_pkg::side_type s7_side_in;
   logic               s6_cond_in;
   logic [31:0]        s6_a_in, s6_b_in;
   logic signed [32:0] scale_ext;
   logic [63:0]        s7_aa_ff, s7_bb_ff;
   logic [63:0]        s8_d_ff;

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[6:0], in_valid};
      end
   end

   // stage 2 combinational: offset add and correction magnitude
   always_comb begin
      s2_lc_in = tofb_pkg::sat32(34'(signed'({1'b0, s1_prodl_ff[PW-1:16]}))
                                 + 34'(cfg.left_offset));
      s2_rc_in = tofb_pkg::sat32(34'(signed'({1'b0, s1_prodr_ff[PW-1:16]}))
                                 + 34'(cfg.right_offset));
      s2_mag_in = s1_psum_ff[16] ? 17'(-s1_psum_ff) : 17'(s1_psum_ff);
   end

   // stage 3 combinational: sum of calibrated times
   assign s3_sum_in = 33'(s2_lc_ff) + 33'(s2_rc_ff);

   // stage 4 combinational: signed correction, then subtract
   always_comb begin
      s4_corr_in = 34'(s3_q_ff[39:tofb_pkg::RECIP3_SHIFT]);
      if (s3_neg_ff) begin
         s4_corr_in = -s4_corr_in;
      end
      if (!s3_fok_ff) begin
         s4_flight_in = '0;
      end else if (s3_apply_ff) begin
         s4_flight_in = tofb_pkg::sat32(34'(s3_flight_ff) - s4_corr_in);
      end else begin
         s4_flight_in = s3_flight_ff;
      end
   end

   // stage 6 combinational: magnitudes and sign agreement
   always_comb begin
      scale_ext  = 33'(cfg.beta_scale_time);
      s6_a_in    = scale_ext[32] ? 32'(-scale_ext) : 32'(scale_ext);
      s6_b_in    = s5_den_ff[32] ? 32'(-s5_den_ff) : 32'(s5_den_ff);
      s6_cond_in = s5_fok_ff && (s5_den_ff != '0) && (scale_ext != '0)
                   && ((s5_den_ff > 0) == (scale_ext > 0));
   end

   // stage 7 combinational: beta below one needs a below b
   always_comb begin
      s7_side_in         = s6_side_ff;
      s7_side_in.beta_ok = s6_side_ff.beta_ok
                           && (s6_side_ff.mag_a < s6_side_ff.mag_b);
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      if (adv) begin
         // calibration products and position sum
         s1_prodl_ff <= PW'(left_raw) * PW'(cfg.left_slope);
         s1_prodr_ff <= PW'(right_raw) * PW'(cfg.right_slope);
         s1_psum_ff  <= 17'(start_position) + 17'(stop_position);
         s1_apply_ff <= cfg.position_correction_on & start_position_ok
                        & stop_position_ok;
         // calibrated times, correction numerator
         s2_lc_ff    <= s2_lc_in;
         s2_rc_ff    <= s2_rc_in;
         s2_n_ff     <= 20'(s2_mag_in) * 20'd10;
         s2_neg_ff   <= s1_psum_ff[16];
         s2_apply_ff <= s1_apply_ff;
         // average and divide by three
         s3_lc_ff     <= s2_lc_ff;
         s3_rc_ff     <= s2_rc_ff;
         s3_fok_ff    <= (34'(s2_lc_ff) > tofb_pkg::TIME_THRESHOLD)
                         && (34'(s2_rc_ff) > tofb_pkg::TIME_THRESHOLD);
         s3_flight_ff <= s3_sum_in[32:1];
         s3_q_ff      <= 40'(s2_n_ff) * 40'(tofb_pkg::RECIP3);
         s3_neg_ff    <= s2_neg_ff;
         s3_apply_ff  <= s2_apply_ff;
         // corrected flight time
         s4_lc_ff     <= s3_lc_ff;
         s4_rc_ff     <= s3_rc_ff;
         s4_fok_ff    <= s3_fok_ff;
         s4_flight_ff <= s4_flight_in;
         // beta divisor
         s5_lc_ff     <= s4_lc_ff;
         s5_rc_ff     <= s4_rc_ff;
         s5_fok_ff    <= s4_fok_ff;
         s5_flight_ff <= s4_flight_ff;
         s5_den_ff    <= 33'(cfg.beta_base_time) - 33'(s4_flight_ff);
         // magnitudes
         s6_side_ff.left_cal    <= s5_lc_ff;
         s6_side_ff.right_cal   <= s5_rc_ff;
         s6_side_ff.flight_ok   <= s5_fok_ff;
         s6_side_ff.flight_time <= s5_flight_ff;
         s6_side_ff.beta_ok     <= s6_cond_in;
         s6_side_ff.mag_a       <= s6_a_in;
         s6_side_ff.mag_b       <= s6_b_in;
         // squares, a below b
         s7_side_ff <= s7_side_in;
         s7_aa_ff <= 64'(s6_side_ff.mag_a) * 64'(s6_side_ff.mag_a);
         s7_bb_ff <= 64'(s6_side_ff.mag_b) * 64'(s6_side_ff.mag_b);
         // radicand b^2 - a^2
         s8_side_ff <= s7_side_ff;
         s8_d_ff    <= s7_bb_ff - s7_aa_ff;
      end
   end

   assign out_valid = v_ff[7];
   assign out_side  = s8_side_ff;
   assign radicand  = s8_d_ff;

endmodule

@@ src/tofb_sqrt.sv @@
// ----------------------------------------------------------------------------
// tofb_sqrt : pipelined integer square root
// One root bit per stage, restoring method; floor of the square root.
// ----------------------------------------------------------------------------
module tofb_sqrt (
   input  logic                            clock,
   input  logic                            adv,
   input  logic [tofb_pkg::RADICAND_W-1:0] radicand,
   output logic [tofb_pkg::ROOT_W-1:0]     root
);

   localparam int RW = tofb_pkg::ROOT_W;
   localparam int XW = tofb_pkg::RADICAND_W;
   localparam int NS = tofb_pkg::ROOT_STAGES;

   logic [XW-1:0] x_ff    [NS];
   logic [RW+1:0] rem_ff  [NS];
   logic [RW-1:0] root_ff [NS];
   logic [XW-1:0] x_in    [NS];
   logic [RW+1:0] rem_in  [NS];
   logic [RW-1:0] root_in [NS];
   logic [XW-1:0] x_prev    [NS];
   logic [RW+1:0] rem_prev  [NS];
   logic [RW-1:0] root_prev [NS];

   // one trial subtraction per stage
   always_comb begin
      logic [RW+3:0] shifted;
      logic [RW+3:0] trial;
      x_prev[0]    = radicand;
      rem_prev[0]  = '0;
      root_prev[0] = '0;
      for (int k = 1; k < NS; k++) begin
         x_prev[k]    = x_ff[k-1];
         rem_prev[k]  = rem_ff[k-1];
         root_prev[k] = root_ff[k-1];
      end
      for (int k = 0; k < NS; k++) begin
         shifted = {rem_prev[k], x_prev[k][XW-1 -: 2]};
         trial   = (RW+4)'({root_prev[k], 2'b01});
         x_in[k] = {x_prev[k][XW-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in[k]  = (RW+2)'(shifted - trial);
            root_in[k] = {root_prev[k][RW-2:0], 1'b1};
         end else begin
            rem_in[k]  = (RW+2)'(shifted);
            root_in[k] = {root_prev[k][RW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NS; k++) begin
            x_ff[k]    <= x_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign root = root_ff[NS-1];

endmodule

@@ src/tofb_div.sv @@
// ----------------------------------------------------------------------------
// tofb_div : pipelined restoring divider
// One quotient bit per stage; the numerator's upper part must be below the
// divisor for the quotient to be exact.
// ----------------------------------------------------------------------------
module tofb_div (
   input  logic                       clock,
   input  logic                       adv,
   input  logic [tofb_pkg::NUM_W-1:0] numer,
   input  logic [tofb_pkg::DVS_W-1:0] divisor,
   output logic [tofb_pkg::QUO_W-1:0] quotient
);

   localparam int QW = tofb_pkg::QUO_W;
   localparam int DW = tofb_pkg::DVS_W;
   localparam int NW = tofb_pkg::NUM_W;
   localparam int NS = tofb_pkg::DIV_STAGES;

   logic [DW-1:0] rem_ff [NS];
   logic [QW-1:0] quo_ff [NS];
   logic [QW-1:0] low_ff [NS];
   logic [DW-1:0] dvs_ff [NS];
   logic [DW-1:0] rem_in [NS];
   logic [QW-1:0] quo_in [NS];
   logic [QW-1:0] low_in [NS];
   logic [DW-1:0] rem_prev [NS];
   logic [QW-1:0] quo_prev [NS];
   logic [QW-1:0] low_prev [NS];
   logic [DW-1:0] dvs_prev [NS];

   // shift one numerator bit in, subtract where it fits
   always_comb begin
      logic [DW:0] t;
      logic        ge;
      rem_prev[0] = DW'(numer[NW-1:QW]);
      quo_prev[0] = '0;
      low_prev[0] = numer[QW-1:0];
      dvs_prev[0] = divisor;
      for (int k = 1; k < NS; k++) begin
         rem_prev[k] = rem_ff[k-1];
         quo_prev[k] = quo_ff[k-1];
         low_prev[k] = low_ff[k-1];
         dvs_prev[k] = dvs_ff[k-1];
      end
      for (int k = 0; k < NS; k++) begin
         t         = {rem_prev[k], low_prev[k][QW-1]};
         ge        = t >= (DW+1)'(dvs_prev[k]);
         rem_in[k] = ge ? DW'(t - (DW+1)'(dvs_prev[k])) : t[DW-1:0];
         quo_in[k] = {quo_prev[k][QW-2:0], ge};
         low_in[k] = {low_prev[k][QW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NS; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            low_ff[k] <= low_in[k];
            dvs_ff[k] <= dvs_prev[k];
         end
      end
   end

   assign quotient = quo_ff[NS-1];

endmodule

@@ src/time_of_flight_beta_calc_top.sv @@
// ----------------------------------------------------------------------------
// time_of_flight_beta_calc_top : time of flight, beta and gamma per event
// Calibrates two converter counts, forms the flight time and derives beta,
// gamma and beta*gamma through a square-root and divider pipeline.
// ----------------------------------------------------------------------------
//   channel  direction  beat
//   req_     in         raw counts, positions, position ok flags
//   rsp_     out        calibrated times, flight time, beta, gamma, beta*gamma
//   csr_     in         register write, one per cycle, no read-back
//
// One event per cycle while results are taken; the pipeline is 8 front-end
// stages, 32 square-root stages (one root bit each), 32 divider stages (one
// quotient bit each) and the output register.
// Reset is synchronous: valid bits clear and config registers take their defaults.
// The whole pipeline advances together whenever the output register is
// empty or being taken, so a stalled beat holds and nothing is repeated.
// ----------------------------------------------------------------------------
module time_of_flight_beta_calc_top (
   input  logic                               clock,
   input  logic                               reset,
   // left_raw, right_raw, start_position, start_position_ok,
   // stop_position, stop_position_ok, zero pad
   input  logic [tofb_pkg::REQ_W-1:0]         req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // left_calibrated, right_calibrated, flight_ok, flight_time, beta_valid,
   // beta_value, gamma_value, beta_gamma, zero pad
   output logic [tofb_pkg::RSP_W-1:0]         rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_wen,
   input  logic [tofb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                        csr_wdata
);

   localparam int SQ = tofb_pkg::ROOT_STAGES;
   localparam int DV = tofb_pkg::DIV_STAGES;

   tofb_pkg::cfg_type  cfg_ff;
   logic               adv;
   logic               front_valid;
   tofb_pkg::side_type front_side;
   logic [tofb_pkg::RADICAND_W-1:0] radicand;
   logic [tofb_pkg::ROOT_W-1:0]     root;

   logic [SQ-1:0]      sq_v_ff;
   tofb_pkg::side_type sq_side_ff [SQ];
   logic [DV-1:0]      dv_v_ff;
   tofb_pkg::fin_type  dv_side_ff [DV];
   tofb_pkg::fin_type  fin_in;
   tofb_pkg::side_type sq_last;

   logic [tofb_pkg::QUO_W-1:0] q_beta, q_gamma, q_bg;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_lc_ff, rsp_rc_ff, rsp_flight_ff;
   logic               rsp_fok_ff, rsp_bv_ff;
   logic [15:0]        rsp_beta_ff;
   logic [31:0]        rsp_gamma_ff, rsp_bg_ff;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_slope             <= 32'd1048576;
         cfg_ff.left_offset            <= '0;
         cfg_ff.right_slope            <= 32'd1048576;
         cfg_ff.right_offset           <= '0;
         cfg_ff.beta_base_time         <= '0;
         cfg_ff.beta_scale_time        <= '0;
         cfg_ff.position_correction_on <= 1'b0;
      end else if (csr_wen) begin
         case (csr_index)
            tofb_pkg::CSR_LEFT_SLOPE:   cfg_ff.left_slope      <= csr_wdata;
            tofb_pkg::CSR_LEFT_OFFSET:  cfg_ff.left_offset     <= csr_wdata;
            tofb_pkg::CSR_RIGHT_SLOPE:  cfg_ff.right_slope     <= csr_wdata;
            tofb_pkg::CSR_RIGHT_OFFSET: cfg_ff.right_offset    <= csr_wdata;
            tofb_pkg::CSR_BETA_BASE:    cfg_ff.beta_base_time  <= csr_wdata;
            tofb_pkg::CSR_BETA_SCALE:   cfg_ff.beta_scale_time <= csr_wdata;
            tofb_pkg::CSR_POS_CORR: cfg_ff.position_correction_on <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // pipeline advance
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   tofb_front u_front (
      .clock             (clock),
      .reset             (reset),
      .adv               (adv),
      .in_valid          (req_tvalid),
      .left_raw          (req_tdata[tofb_pkg::IN_LEFT_LO +: tofb_pkg::RAW_BITS]),
      .right_raw         (req_tdata[tofb_pkg::IN_RIGHT_LO +: tofb_pkg::RAW_BITS]),
      .start_position    (req_tdata[tofb_pkg::IN_START_LO +: 16]),
      .start_position_ok (req_tdata[tofb_pkg::IN_START_OK]),
      .stop_position     (req_tdata[tofb_pkg::IN_STOP_LO +: 16]),
      .stop_position_ok  (req_tdata[tofb_pkg::IN_STOP_OK]),
      .cfg               (cfg_ff),
      .out_valid         (front_valid),
      .out_side          (front_side),
      .radicand          (radicand)
   );

   tofb_sqrt u_sqrt (
      .clock    (clock),
      .adv      (adv),
      .radicand (radicand),
      .root     (root)
   );

   // sideband alongside the square root
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff <= '0;
      end else if (adv) begin
         sq_v_ff <= {sq_v_ff[SQ-2:0], front_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_side_ff[0] <= front_side;
         for (int k = 1; k < SQ; k++) begin
            sq_side_ff[k] <= sq_side_ff[k-1];
         end
      end
   end

   // saturation tests: quotient reaches 2^32 when numerator >> 32 >= divisor
   always_comb begin
      sq_last            = sq_side_ff[SQ-1];
      fin_in.left_cal    = sq_last.left_cal;
      fin_in.right_cal   = sq_last.right_cal;
      fin_in.flight_ok   = sq_last.flight_ok;
      fin_in.flight_time = sq_last.flight_time;
      fin_in.beta_ok     = sq_last.beta_ok;
      fin_in.gamma_sat   = 32'(sq_last.mag_b[31:16]) >= root;
      fin_in.bg_sat      = 32'(sq_last.mag_a[31:16]) >= root;
   end

   tofb_div u_div_beta (
      .clock    (clock),
      .adv      (adv),
      .numer    ({sq_last.mag_a, 16'd0}),
      .divisor  (sq_last.mag_b),
      .quotient (q_beta)
   );

   tofb_div u_div_gamma (
      .clock    (clock),
      .adv      (adv),
      .numer    ({sq_last.mag_b, 16'd0}),
      .divisor  (root),
      .quotient (q_gamma)
   );

   tofb_div u_div_bg (
      .clock    (clock),
      .adv      (adv),
      .numer    ({sq_last.mag_a, 16'd0}),
      .divisor  (root),
      .quotient (q_bg)
   );

   // sideband alongside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff <= '0;
      end else if (adv) begin
         dv_v_ff <= {dv_v_ff[DV-2:0], sq_v_ff[SQ-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_side_ff[0] <= fin_in;
         for (int k = 1; k < DV; k++) begin
            dv_side_ff[k] <= dv_side_ff[k-1];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_v_ff[DV-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_lc_ff     <= dv_side_ff[DV-1].left_cal;
         rsp_rc_ff     <= dv_side_ff[DV-1].right_cal;
         rsp_fok_ff    <= dv_side_ff[DV-1].flight_ok;
         rsp_flight_ff <= dv_side_ff[DV-1].flight_time;
         rsp_bv_ff     <= dv_side_ff[DV-1].beta_ok;
         if (dv_side_ff[DV-1].beta_ok) begin
            rsp_beta_ff  <= q_beta[15:0];
            rsp_gamma_ff <= dv_side_ff[DV-1].gamma_sat ? 32'hFFFF_FFFF : q_gamma;
            rsp_bg_ff    <= dv_side_ff[DV-1].bg_sat ? 32'hFFFF_FFFF : q_bg;
         end else begin
            rsp_beta_ff  <= '0;
            rsp_gamma_ff <= '0;
            rsp_bg_ff    <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(tofb_pkg::RSP_W - tofb_pkg::RSP_BITS)'(0),
                        rsp_bg_ff, rsp_gamma_ff, rsp_beta_ff, rsp_bv_ff,
                        rsp_flight_ff, rsp_fok_ff, rsp_rc_ff, rsp_lc_ff};

   // checks
   a_beta_needs_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bv_ff |-> rsp_fok_ff)
      else $error("beta valid without flight ok");

   a_no_flight_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_fok_ff |-> (rsp_flight_ff == '0) && (rsp_beta_ff == '0)
                                      && (rsp_gamma_ff == '0) && (rsp_bg_ff == '0))
      else $error("results not cleared without flight ok");

   a_gamma_at_least_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bv_ff |-> rsp_gamma_ff >= 32'h0001_0000)
      else $error("gamma below one");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && (dv_v_ff == '0) && (sq_v_ff == '0))
      else $error("pipeline not empty after reset");

endmodule

@@ dv/time_of_flight_beta_calc_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_of_flight_beta_calc_top_test : event stream check of the beta pipeline
// Writes calibration settings, sends events through the stream ports, predicts
// calibrated times, flight time, beta, gamma and beta*gamma per event, and
// compares every result beat in order while both sides idle at random.
// ----------------------------------------------------------------------------
module time_of_flight_beta_calc_top_test;

   localparam int LATENCY   = 73;
   localparam int WDOG_MAX  = 20000;
   localparam int RB        = tofb_pkg::RAW_BITS;

   typedef struct packed {
      logic [31:0] bg;
      logic [31:0] gamma;
      logic [15:0] beta;
      logic        bvalid;
      logic [31:0] flight;
      logic        fok;
      logic [31:0] rcal;
      logic [31:0] lcal;
   } tof_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic [tofb_pkg::REQ_W-1:0]     req_tdata = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [tofb_pkg::RSP_W-1:0]     rsp_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic                           csr_wen = 1'b0;
   logic [tofb_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]                    csr_wdata = '0;

   // local copy of the register file
   logic [31:0]        m_lslope, m_rslope;
   logic signed [31:0] m_loff, m_roff, m_base, m_scale;
   logic               m_corr;

   tof_result_type expected_results[$];
   int  errors = 0;
   int  results_seen = 0;
   int  wdog = 0;
   int  burst_left = 0;
   bit  hold_rx = 1'b0;
   bit  hold_long = 1'b0;

   time_of_flight_beta_calc_top dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // square root, floor
   function automatic logic [63:0] root_floor(input logic [63:0] x);
      logic [63:0] res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v >>= 2;
      while (bit_v != 0) begin
         if (x >= res + bit_v) begin
            x = x - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v >>= 2;
      end
      return res;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint time_from_count(input logic [RB-1:0] raw,
                                              input logic [31:0] slope,
                                              input logic signed [31:0] offs);
      logic [63:0] prod;
      prod = 64'(raw) * 64'(slope);
      return clamp32(longint'(prod >> 16) + longint'(offs));
   endfunction

   function automatic tof_result_type predict_event(input logic [RB-1:0] lr,
         input logic [RB-1:0] rr, input logic signed [15:0] p1,
         input logic ok1, input logic signed [15:0] p2, input logic ok2);
      tof_result_type r;
      longint lc, rc, fl, den, corr;
      logic [63:0] a, b, s, q;
      r = '0;
      lc = time_from_count(lr, m_lslope, m_loff);
      rc = time_from_count(rr, m_rslope, m_roff);
      r.lcal = lc[31:0];
      r.rcal = rc[31:0];
      r.fok = (lc > 24000) && (rc > 24000);
      if (r.fok) begin
         fl = (lc + rc) / 2;
         if (m_corr && ok1 && ok2) begin
            corr = ((longint'(p1) + longint'(p2)) * 10) / 3;
            fl = clamp32(fl - corr);
         end
         r.flight = fl[31:0];
         den = longint'(m_base) - fl;
         if (den != 0 && m_scale != 0 && ((den > 0) == (m_scale > 0))) begin
            a = (m_scale < 0) ? -longint'(m_scale) : longint'(m_scale);
            b = (den < 0) ? -den : den;
            if (a < b) begin
               s = root_floor((b - a) * (b + a));
               r.bvalid = 1'b1;
               q = (a << 16) / b;
               r.beta = q[15:0];
               q = (b << 16) / s;
               r.gamma = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
               q = (a << 16) / s;
               r.bg = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want,
               results_seen);
   endtask

   // result checker
   always @(posedge clock) begin
      tof_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[tofb_pkg::RSP_BITS-1:0];
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result beat", 64'd0, 64'd0);
         end else begin
            want = expected_results.pop_front();
            if (got.lcal !== want.lcal) report_mismatch("left_cal", got.lcal, want.lcal);
            if (got.rcal !== want.rcal) report_mismatch("right_cal", got.rcal, want.rcal);
            if (got.fok !== want.fok) report_mismatch("flight_ok", got.fok, want.fok);
            if (got.flight !== want.flight)
               report_mismatch("flight_time", got.flight, want.flight);
            if (got.bvalid !== want.bvalid)
               report_mismatch("beta_valid", got.bvalid, want.bvalid);
            if (got.beta !== want.beta) report_mismatch("beta", got.beta, want.beta);
            if (got.gamma !== want.gamma) report_mismatch("gamma", got.gamma, want.gamma);
            if (got.bg !== want.bg) report_mismatch("beta_gamma", got.bg, want.bg);
         end
         results_seen++;
      end
   end

   // receiver stall pattern, with an optional long hold-off
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_rx) begin
         rsp_tready <= 1'b0;
      end else begin
         n = $urandom_range(0, 15);
         rsp_tready <= (n < 3) ? 1'b0 : 1'b1;
      end
   end

   initial begin
      wait (!reset);
      forever begin
         wait (hold_long);
         hold_rx = 1'b1;
         repeat (300) @(posedge clock);
         hold_rx = 1'b0;
         hold_long = 1'b0;
      end
   end

   // watchdog on accepted beats
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen)
            wdog <= 0;
         else
            wdog <= wdog + 1;
         if (wdog >= WDOG_MAX) begin
            $display("watchdog expired, %0d results outstanding",
                     expected_results.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic send_event(input logic [RB-1:0] lr, input logic [RB-1:0] rr,
                             input logic signed [15:0] p1, input logic ok1,
                             input logic signed [15:0] p2, input logic ok2);
      logic [tofb_pkg::REQ_W-1:0] d;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      d = '0;
      d[tofb_pkg::IN_LEFT_LO +: RB]  = lr;
      d[tofb_pkg::IN_RIGHT_LO +: RB] = rr;
      d[tofb_pkg::IN_START_LO +: 16] = p1;
      d[tofb_pkg::IN_START_OK]       = ok1;
      d[tofb_pkg::IN_STOP_LO +: 16]  = p2;
      d[tofb_pkg::IN_STOP_OK]        = ok2;
      req_tdata  <= d;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.insert(expected_results.size(),
                              predict_event(lr, rr, p1, ok1, p2, ok2));
      burst_left--;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input tofb_pkg::csr_index_type idx, input logic [31:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         tofb_pkg::CSR_LEFT_SLOPE:   m_lslope = val;
         tofb_pkg::CSR_LEFT_OFFSET:  m_loff   = val;
         tofb_pkg::CSR_RIGHT_SLOPE:  m_rslope = val;
         tofb_pkg::CSR_RIGHT_OFFSET: m_roff   = val;
         tofb_pkg::CSR_BETA_BASE:    m_base   = val;
         tofb_pkg::CSR_BETA_SCALE:   m_scale  = val;
         tofb_pkg::CSR_POS_CORR:     m_corr   = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_all(input logic [31:0] ls, input logic [31:0] lo,
                          input logic [31:0] rs, input logic [31:0] ro,
                          input logic [31:0] bs, input logic [31:0] sc,
                          input logic corr);
      write_reg(tofb_pkg::CSR_LEFT_SLOPE, ls);
      write_reg(tofb_pkg::CSR_LEFT_OFFSET, lo);
      write_reg(tofb_pkg::CSR_RIGHT_SLOPE, rs);
      write_reg(tofb_pkg::CSR_RIGHT_OFFSET, ro);
      write_reg(tofb_pkg::CSR_BETA_BASE, bs);
      write_reg(tofb_pkg::CSR_BETA_SCALE, sc);
      write_reg(tofb_pkg::CSR_POS_CORR, {31'd0, corr});
   endtask

   task automatic send_random_event(input int pos_span);
      send_event(RB'($urandom), RB'($urandom),
                 (pos_span == 0) ? 16'($urandom) : 16'($urandom_range(0, 2*pos_span) - pos_span),
                 $urandom_range(0, 3) != 0,
                 (pos_span == 0) ? 16'($urandom) : 16'($urandom_range(0, 2*pos_span) - pos_span),
                 $urandom_range(0, 3) != 0);
   endtask

   // defaults after reset: flight ok only for large counts, beta never valid
   task automatic test_reset_defaults;
      send_event('0, '0, 16'sd0, 1'b0, 16'sd0, 1'b0);
      send_event('1, '1, 16'sh7FFF, 1'b1, 16'sh8000, 1'b1);
      send_event(12'd1500, 12'd1501, 16'sd5, 1'b1, 16'sd5, 1'b1);
      send_event(12'd1501, 12'd1501, 16'sd5, 1'b1, 16'sd5, 1'b1);
      drain();
   endtask

   // directed corners: saturation, threshold, zero divisor, beta edges, correction
   task automatic test_directed_corners;
      set_all(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      send_event('1, '1, 16'sh8000, 1'b1, 16'sh8000, 1'b1);
      send_event('0, '1, 16'sh7FFF, 1'b1, 16'sh7FFF, 1'b1);
      drain();
      // offset only: threshold exactly, correction sign, beta region
      set_all(32'd0, 32'd24001, 32'd0, 32'd24001, 32'd100000, 32'd50000, 1'b1);
      send_event('0, '0, 16'sd0, 1'b1, 16'sd0, 1'b1);
      send_event('0, '0, 16'sd1, 1'b1, 16'sd1, 1'b1);
      send_event('0, '0, -16'sd1, 1'b1, -16'sd1, 1'b0);
      send_event('0, '0, 16'sh7FFF, 1'b1, 16'sh7FFF, 1'b1);
      send_event('0, '0, 16'sh8000, 1'b0, 16'sh8000, 1'b1);
      drain();
      write_reg(tofb_pkg::CSR_LEFT_OFFSET, 32'd24000);
      send_event('0, '0, 16'sd0, 1'b0, 16'sd0, 1'b0);
      drain();
      // zero divisor, beta one, beta tiny, negative both, wrong sign
      set_all(32'd0, 32'd30000, 32'd0, 32'd30000, 32'd30000, 32'd1000, 1'b0);
      send_event('0, '0, 16'sd0, 1'b0, 16'sd0, 1'b0);
      drain();
      write_reg(tofb_pkg::CSR_BETA_BASE, 32'd40000);
      write_reg(tofb_pkg::CSR_BETA_SCALE, 32'd10000);
      send_event('0, '0, 16'sd0, 1'b0, 16'sd0, 1'b0);
      drain();
      write_reg(tofb_pkg::CSR_BETA_SCALE, 32'd9999);
      send_event('0, '0, 16'sd0, 1'b0, 16'sd0, 1'b0);
      drain();
      write_reg(tofb_pkg::CSR_BETA_SCALE, 32'd1);
      send_event('0, '0, 16'sd0, 1'b0, 16'sd0, 1'b0);
      drain();
      write_reg(tofb_pkg::CSR_BETA_BASE, 32'd0);
      write_reg(tofb_pkg::CSR_BETA_SCALE, -32'sd29999);
      send_event('0, '0, 16'sd0, 1'b0, 16'sd0, 1'b0);
      drain();
      write_reg(tofb_pkg::CSR_BETA_SCALE, 32'd20000);
      send_event('0, '0, 16'sd0, 1'b0, 16'sd0, 1'b0);
      drain();
   endtask

   // random events over several settings, mostly in the beta-valid region
   task automatic test_random_events;
      logic [31:0] ls, rs, lo, ro, bs, sc;
      int pick;
      for (int phase = 0; phase < 16; phase++) begin
         pick = $urandom_range(0, 4);
         ls = (pick == 0) ? $urandom : $urandom_range(1 << 20, 40 << 20);
         rs = (pick == 0) ? $urandom : $urandom_range(1 << 20, 40 << 20);
         lo = (pick == 0) ? $urandom : $urandom_range(0, 60000);
         ro = (pick == 0) ? $urandom : $urandom_range(0, 60000);
         bs = (pick == 1) ? $urandom : $urandom_range(0, 5000000);
         sc = (pick == 1) ? $urandom : $urandom_range(0, 3000000) - 1000000;
         set_all(ls, lo, rs, ro, bs, sc, 1'($urandom_range(0, 1)));
         for (int i = 0; i < 100; i++) begin
            send_random_event(($urandom_range(0, 3) == 0) ? 0 : 3000);
         end
         drain();
      end
   endtask

   // long receiver hold-off while the sender keeps offering beats
   task automatic test_backpressure;
      set_all(32'd4 << 20, 32'd1000, 32'd5 << 20, 32'd2000, 32'd3000000, 32'd400000, 1'b1);
      hold_long = 1'b1;
      for (int i = 0; i < 150; i++) send_random_event(2000);
      drain();
   endtask

   initial begin
      m_lslope = 32'd1048576; m_rslope = 32'd1048576;
      m_loff = 0; m_roff = 0; m_base = 0; m_scale = 0; m_corr = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_corners();
      test_backpressure();
      test_random_events();
      repeat (LATENCY + 10) @(posedge clock);
      $display("Covered register extremes, threshold, divisor and beta edge cases, a");
      $display("long output stall and %0d result beats over random settings.",
               results_seen);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, expected_results.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
